/* hdl/ttd_pkg.sv */
// ttd_pkg: shared types and constants of the time-triggered task dispatcher.
// Used by ttd_core and time_triggered_task_dispatcher_unit.
// No dependencies.
`timescale 1ns / 1ps

package ttd_pkg;

  // Default table depth (periodic and sporadic tables alike)
  localparam int MAX_TASKS_DEF = 8;

  // Idle value reported when no periodic task runs
  localparam logic [15:0] IDLE_NONE = 16'hFFFF;

  // Input commands
  typedef enum logic [1:0] {
    ACT_ADD_PERIODIC = 2'd0,
    ACT_ADD_SPORADIC = 2'd1,
    ACT_SET_PERIOD   = 2'd2,
    ACT_DISPATCH     = 2'd3
  } action_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_SETP,
    ST_PER,
    ST_SPO,
    ST_DONE
  } state_t;

  // One input transaction
  typedef struct packed {
    action_t            action;
    logic [2:0]         slot;
    logic signed [15:0] delay_ms;
    logic [14:0]        period_ms;
    logic [15:0]        execution_ms;
    logic [15:0]        elapsed_ms;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic        periodic_fired;
    logic [2:0]  periodic_slot;
    logic        sporadic_fired;
    logic [2:0]  sporadic_slot;
    logic [15:0] idle_ms;
  } res_t;

  // Table entry: periodic {remaining, period}, sporadic {delay, exec}
  typedef struct packed {
    logic [15:0] time_ms;
    logic [15:0] param_ms;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Due when zero or negative as a signed 16-bit value
  function automatic logic due16(logic [15:0] v);
    return (v == 16'd0) || v[15];
  endfunction

endpackage

/* hdl/time_triggered_task_dispatcher_unit.sv */
// time_triggered_task_dispatcher_unit: top level, port handshakes and result register.
// Depends on ttd_pkg and ttd_core.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in_     | input     | in_valid/in_stall   | action, slot, delay, period, exec, elapsed
//   out_    | output    | out_valid/out_stall | fired flags, slots, idle_ms
//
// Add periodic, add sporadic: written in the command state if there is room. Set period:
// read the slot entry, then write it back with the new period (skipped on a slot not
// running). Dispatch tick: walk the N running periodic entries, then all MAX_TASKS
// sporadic entries, one entry per cycle; with idle_ms zero the sporadic walk is skipped.
// Reset is synchronous; table memories need no clearing pass.
// A result waits in the output register while the next transaction is taken;
// a new result waits in the core while out_stall holds the previous one.
`timescale 1ns / 1ps

module time_triggered_task_dispatcher_unit #(
  parameter int MAX_TASKS = ttd_pkg::MAX_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_slot,
  input  logic signed [15:0] in_delay_ms,
  input  logic [14:0]        in_period_ms,
  input  logic [15:0]        in_execution_ms,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_periodic_fired,
  output logic [2:0]         out_periodic_slot,
  output logic               out_sporadic_fired,
  output logic [2:0]         out_sporadic_slot,
  output logic [15:0]        out_idle_ms
);

  ttd_pkg::item_t item;
  ttd_pkg::res_t  res;
  ttd_pkg::res_t  out_res_r, out_res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic core_ready, res_valid, res_take, in_take;

  // Input transaction
  assign in_stall = !core_ready;
  assign in_take  = in_valid && core_ready;
  assign item = '{action: ttd_pkg::action_t'(in_action), slot: in_slot,
                  delay_ms: in_delay_ms, period_ms: in_period_ms,
                  execution_ms: in_execution_ms, elapsed_ms: in_elapsed_ms};

  ttd_core #(.MAX_TASKS(MAX_TASKS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(in_take),
    .item      (item),
    .ready     (core_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_periodic_fired = out_res_r.periodic_fired;
  assign out_periodic_slot  = out_res_r.periodic_slot;
  assign out_sporadic_fired = out_res_r.sporadic_fired;
  assign out_sporadic_slot  = out_res_r.sporadic_slot;
  assign out_idle_ms        = out_res_r.idle_ms;

endmodule

/* hdl/ttd_ram.sv */
// ttd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ttd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/ttd_core.sv */
// ttd_core: command sequencer, table walks and the two table memories.
// Depends on ttd_pkg and ttd_ram.
`timescale 1ns / 1ps

module ttd_core #(
  parameter int MAX_TASKS = ttd_pkg::MAX_TASKS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  ttd_pkg::item_t item,
  output logic           ready,
  output logic           res_valid,
  input  logic           res_take,
  output ttd_pkg::res_t  res
);

  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int IDX_W = $clog2(MAX_TASKS + 1);
  localparam int CW    = (IDX_W > 3) ? IDX_W : 3;
  localparam int OW    = (AW > 3) ? AW : 3;

  // Control state
  ttd_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [MAX_TASKS-1:0] svalid_r, svalid_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic proc_r, proc_nxt;

  // Payload state
  ttd_pkg::item_t item_r, item_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic [15:0] age_r, age_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic pf_r, pf_nxt;
  logic sf_r, sf_nxt;
  logic [AW-1:0] ps_r, ps_nxt;
  logic [AW-1:0] ss_r, ss_nxt;

  // Memory ports
  logic p_wr_en, p_rd_en, s_wr_en, s_rd_en;
  logic [AW-1:0] p_wr_addr, p_rd_addr, s_wr_addr, s_rd_addr;
  ttd_pkg::entry_t p_wr_data, p_rd_data, s_wr_data, s_rd_data;
  logic [ttd_pkg::ENTRY_W-1:0] p_rd_raw, s_rd_raw;

  // Derived conditions
  logic per_issue, spo_issue, slot_ok, free_any;
  logic [AW-1:0] free_idx, slot_addr;
  logic [CW-1:0] slot_ext;
  logic [OW-1:0] ps_ext, ss_ext;
  logic [15:0] pend_sum;
  logic [15:0] p_rem0, p_rem;
  logic p_due, p_fire;
  logic [15:0] s_delay;
  logic s_live, s_fire;

  ttd_ram #(.WIDTH(ttd_pkg::ENTRY_W), .DEPTH(MAX_TASKS)) u_per_ram (
    .clk    (clk),
    .wr_en  (p_wr_en),
    .wr_addr(p_wr_addr),
    .wr_data(p_wr_data),
    .rd_en  (p_rd_en),
    .rd_addr(p_rd_addr),
    .rd_data(p_rd_raw)
  );

  ttd_ram #(.WIDTH(ttd_pkg::ENTRY_W), .DEPTH(MAX_TASKS)) u_spo_ram (
    .clk    (clk),
    .wr_en  (s_wr_en),
    .wr_addr(s_wr_addr),
    .wr_data(s_wr_data),
    .rd_en  (s_rd_en),
    .rd_addr(s_rd_addr),
    .rd_data(s_rd_raw)
  );

  assign p_rd_data = p_rd_raw;
  assign s_rd_data = s_rd_raw;

  // Walk and command conditions
  assign per_issue = (idx_r < cnt_r);
  assign spo_issue = (idx_r < IDX_W'(MAX_TASKS));
  assign slot_ext  = CW'(item_r.slot);
  assign slot_ok   = (slot_ext < CW'(cnt_r));
  assign slot_addr = slot_ext[AW-1:0];
  assign pend_sum  = pend_r + item_r.elapsed_ms;

  // Lowest free sporadic slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!svalid_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  // Periodic countdown of the entry coming out of memory
  always_comb begin
    p_rem0 = p_rd_data.time_ms - item_r.elapsed_ms;
    p_due  = ttd_pkg::due16(p_rem0);
    p_fire = p_due && !pf_r;
    p_rem  = p_fire ? (p_rem0 + p_rd_data.param_ms) : p_rem0;
  end

  // Sporadic aging and slack-fit check
  always_comb begin
    s_delay = s_rd_data.time_ms - age_r;
    s_live  = proc_r && svalid_r[pidx_r];
    s_fire  = s_live && !sf_r && ttd_pkg::due16(s_delay) &&
              (s_rd_data.param_ms <= idle_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttd_pkg::ST_IDLE: begin
        if (item_valid) state_nxt = ttd_pkg::ST_CMD;
      end
      ttd_pkg::ST_CMD: begin
        unique case (item_r.action)
          ttd_pkg::ACT_SET_PERIOD:
            state_nxt = slot_ok ? ttd_pkg::ST_SETP : ttd_pkg::ST_IDLE;
          ttd_pkg::ACT_DISPATCH: state_nxt = ttd_pkg::ST_PER;
          default:               state_nxt = ttd_pkg::ST_IDLE;
        endcase
      end
      ttd_pkg::ST_SETP: state_nxt = ttd_pkg::ST_IDLE;
      ttd_pkg::ST_PER: begin
        if (!per_issue && !proc_r) begin
          state_nxt = (idle_r != 16'd0) ? ttd_pkg::ST_SPO : ttd_pkg::ST_DONE;
        end
      end
      ttd_pkg::ST_SPO: begin
        if (!spo_issue && !proc_r) state_nxt = ttd_pkg::ST_DONE;
      end
      ttd_pkg::ST_DONE: begin
        if (res_take) state_nxt = ttd_pkg::ST_IDLE;
      end
      default: state_nxt = ttd_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory accesses
  always_comb begin
    ready     = 1'b0;
    res_valid = 1'b0;
    p_wr_en   = 1'b0;
    p_wr_addr = '0;
    p_wr_data = '0;
    p_rd_en   = 1'b0;
    p_rd_addr = '0;
    s_wr_en   = 1'b0;
    s_wr_addr = '0;
    s_wr_data = '0;
    s_rd_en   = 1'b0;
    s_rd_addr = '0;
    unique case (state_r)
      ttd_pkg::ST_IDLE: ready = 1'b1;
      ttd_pkg::ST_CMD: begin
        unique case (item_r.action)
          ttd_pkg::ACT_ADD_PERIODIC: begin
            p_wr_en   = (cnt_r < IDX_W'(MAX_TASKS));
            p_wr_addr = cnt_r[AW-1:0];
            p_wr_data = '{time_ms: item_r.delay_ms, param_ms: {1'b0, item_r.period_ms}};
          end
          ttd_pkg::ACT_ADD_SPORADIC: begin
            s_wr_en   = free_any;
            s_wr_addr = free_idx;
            s_wr_data = '{time_ms: item_r.delay_ms, param_ms: item_r.execution_ms};
          end
          ttd_pkg::ACT_SET_PERIOD: begin
            p_rd_en   = slot_ok;
            p_rd_addr = slot_addr;
          end
          default: ;
        endcase
      end
      ttd_pkg::ST_SETP: begin
        // keep remaining time, replace period
        p_wr_en   = 1'b1;
        p_wr_addr = slot_addr;
        p_wr_data = '{time_ms: p_rd_data.time_ms, param_ms: {1'b0, item_r.period_ms}};
      end
      ttd_pkg::ST_PER: begin
        p_rd_en   = per_issue;
        p_rd_addr = idx_r[AW-1:0];
        p_wr_en   = proc_r;
        p_wr_addr = pidx_r;
        p_wr_data = '{time_ms: p_rem, param_ms: p_rd_data.param_ms};
      end
      ttd_pkg::ST_SPO: begin
        s_rd_en   = spo_issue;
        s_rd_addr = idx_r[AW-1:0];
        s_wr_en   = s_live;
        s_wr_addr = pidx_r;
        s_wr_data = '{time_ms: s_delay, param_ms: s_rd_data.param_ms};
      end
      ttd_pkg::ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    item_nxt   = item_r;
    cnt_nxt    = cnt_r;
    svalid_nxt = svalid_r;
    pend_nxt   = pend_r;
    proc_nxt   = 1'b0;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    age_nxt    = age_r;
    idle_nxt   = idle_r;
    pf_nxt     = pf_r;
    sf_nxt     = sf_r;
    ps_nxt     = ps_r;
    ss_nxt     = ss_r;
    unique case (state_r)
      ttd_pkg::ST_IDLE: begin
        if (item_valid) item_nxt = item;
      end
      ttd_pkg::ST_CMD: begin
        unique case (item_r.action)
          ttd_pkg::ACT_ADD_PERIODIC: begin
            if (cnt_r < IDX_W'(MAX_TASKS)) cnt_nxt = cnt_r + IDX_W'(1);
          end
          ttd_pkg::ACT_ADD_SPORADIC: begin
            if (free_any) svalid_nxt[free_idx] = 1'b1;
          end
          ttd_pkg::ACT_DISPATCH: begin
            idx_nxt  = '0;
            pf_nxt   = 1'b0;
            ps_nxt   = '0;
            sf_nxt   = 1'b0;
            ss_nxt   = '0;
            idle_nxt = ttd_pkg::IDLE_NONE;
          end
          default: ;
        endcase
      end
      ttd_pkg::ST_PER: begin
        proc_nxt = per_issue;
        pidx_nxt = idx_r[AW-1:0];
        if (per_issue) idx_nxt = idx_r + IDX_W'(1);
        if (proc_r) begin
          if (p_due) begin
            idle_nxt = 16'd0;
            if (p_fire) begin
              pf_nxt = 1'b1;
              ps_nxt = pidx_r;
            end
          end else if (p_rem0 < idle_r) begin
            idle_nxt = p_rem0;
          end
        end
        // end of walk: settle the gathered elapsed time
        if (!per_issue && !proc_r) begin
          idx_nxt = '0;
          if (idle_r != 16'd0) begin
            age_nxt  = pend_sum;
            pend_nxt = 16'd0;
          end else begin
            pend_nxt = pend_sum;
          end
        end
      end
      ttd_pkg::ST_SPO: begin
        proc_nxt = spo_issue;
        pidx_nxt = idx_r[AW-1:0];
        if (spo_issue) idx_nxt = idx_r + IDX_W'(1);
        if (s_fire) begin
          sf_nxt               = 1'b1;
          ss_nxt               = pidx_r;
          svalid_nxt[pidx_r]   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ttd_pkg::ST_IDLE;
      cnt_r    <= '0;
      svalid_r <= '0;
      pend_r   <= 16'd0;
      proc_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      svalid_r <= svalid_nxt;
      pend_r   <= pend_nxt;
      proc_r   <= proc_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    age_r  <= age_nxt;
    idle_r <= idle_nxt;
    pf_r   <= pf_nxt;
    sf_r   <= sf_nxt;
    ps_r   <= ps_nxt;
    ss_r   <= ss_nxt;
  end

  // Result: slot numbers reported modulo 8
  assign ps_ext = OW'(ps_r);
  assign ss_ext = OW'(ss_r);
  assign res = '{periodic_fired: pf_r, periodic_slot: ps_ext[2:0],
                 sporadic_fired: sf_r, sporadic_slot: ss_ext[2:0],
                 idle_ms: idle_r};

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IDX_W'(MAX_TASKS))
    else $error("periodic count beyond table depth");

  a_per_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (p_rd_en && p_wr_en) |-> (p_rd_addr != p_wr_addr))
    else $error("periodic read and write hit the same entry");

  a_spo_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (s_rd_en && s_wr_en) |-> (s_rd_addr != s_wr_addr))
    else $error("sporadic read and write hit the same entry");

  a_no_slack_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttd_pkg::ST_DONE && idle_r == 16'd0) |-> !sf_r)
    else $error("sporadic task fired without slack");

  a_fire_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttd_pkg::ST_DONE && pf_r) |-> (idle_r == 16'd0))
    else $error("periodic task fired with nonzero idle");

endmodule
